FILE: src/i2c_mbe_pkg.sv
// Shared types, command codes and the phase table of the I2C master byte engine.
// No dependencies; imported by i2c_mbe_seq, i2c_mbe_obuf and the core top level.
package i2c_mbe_pkg;

    // Widths fixed by the bus fields, and the size of the phase table
    localparam int UNIT_TICKS_WIDTH  = 16;
    localparam int UCW_DEFAULT       = 16;
    localparam int PHASE_COUNT       = 23;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;

    // Line codes inside a phase: plain level, keep as is, or data bit
    localparam logic [1:0] LVL_LOW   = 2'd0;
    localparam logic [1:0] LVL_HIGH  = 2'd1;
    localparam logic [1:0] LVL_KEEP  = 2'd2;
    localparam logic [1:0] LVL_DATA  = 2'd3;

    // Phase flags
    localparam logic [3:0] FLAG_ACK  = 4'd1;
    localparam logic [3:0] FLAG_BIT  = 4'd2;
    localparam logic [3:0] FLAG_LOOP = 4'd4;
    localparam logic [3:0] FLAG_END  = 4'd8;

    typedef struct packed {
        logic [1:0] scl;
        logic [1:0] sda;
        logic [1:0] units;
        logic [3:0] flags;
        logic [4:0] target;
    } t_phase;

    // One result beat
    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } t_result;

    // Phase schedule of all five commands
    function automatic t_phase phase_rom(input logic [4:0] idx);
        t_phase p;
        p = '{LVL_KEEP, LVL_KEEP, 2'd1, 4'd0, 5'd0};
        case (idx)
            // start
            5'd0:  p = '{LVL_KEEP, LVL_HIGH, 2'd1, 4'd0,      5'd0};
            5'd1:  p = '{LVL_HIGH, LVL_KEEP, 2'd2, 4'd0,      5'd0};
            5'd2:  p = '{LVL_KEEP, LVL_LOW,  2'd2, 4'd0,      5'd0};
            5'd3:  p = '{LVL_LOW,  LVL_KEEP, 2'd1, FLAG_END,  5'd0};
            // stop
            5'd4:  p = '{LVL_KEEP, LVL_LOW,  2'd1, 4'd0,      5'd0};
            5'd5:  p = '{LVL_HIGH, LVL_KEEP, 2'd2, 4'd0,      5'd0};
            5'd6:  p = '{LVL_KEEP, LVL_HIGH, 2'd1, FLAG_END,  5'd0};
            // write byte
            5'd7:  p = '{LVL_KEEP, LVL_DATA, 2'd1, 4'd0,      5'd0};
            5'd8:  p = '{LVL_HIGH, LVL_KEEP, 2'd1, FLAG_LOOP, 5'd9};
            5'd9:  p = '{LVL_LOW,  LVL_DATA, 2'd1, 4'd0,      5'd0};
            5'd10: p = '{LVL_HIGH, LVL_KEEP, 2'd1, FLAG_LOOP, 5'd9};
            5'd11: p = '{LVL_LOW,  LVL_KEEP, 2'd1, 4'd0,      5'd0};
            5'd12: p = '{LVL_KEEP, LVL_HIGH, 2'd1, 4'd0,      5'd0};
            5'd13: p = '{LVL_HIGH, LVL_KEEP, 2'd1, FLAG_ACK,  5'd0};
            5'd14: p = '{LVL_LOW,  LVL_KEEP, 2'd1, FLAG_END,  5'd0};
            // read byte
            5'd15: p = '{LVL_KEEP, LVL_HIGH, 2'd1, 4'd0,      5'd0};
            5'd16: p = '{LVL_LOW,  LVL_KEEP, 2'd2, 4'd0,      5'd0};
            5'd17: p = '{LVL_HIGH, LVL_KEEP, 2'd2, FLAG_BIT,  5'd0};
            5'd18: p = '{LVL_KEEP, LVL_KEEP, 2'd1, FLAG_LOOP, 5'd15};
            5'd19: p = '{LVL_LOW,  LVL_KEEP, 2'd1, FLAG_END,  5'd0};
            // send acknowledge
            5'd20: p = '{LVL_KEEP, LVL_DATA, 2'd1, 4'd0,      5'd0};
            5'd21: p = '{LVL_HIGH, LVL_KEEP, 2'd2, 4'd0,      5'd0};
            5'd22: p = '{LVL_LOW,  LVL_KEEP, 2'd1, FLAG_END,  5'd0};
            default: p = '{LVL_KEEP, LVL_KEEP, 2'd1, 4'd0, 5'd0};
        endcase
        return p;
    endfunction

    // First phase of each command
    function automatic logic [4:0] cmd_base(input logic [2:0] op);
        logic [4:0] b;
        b = 5'd0;
        case (op)
            CMD_STOP:  b = 5'd4;
            CMD_WRITE: b = 5'd7;
            CMD_READ:  b = 5'd15;
            CMD_ACK:   b = 5'd20;
            default:   b = 5'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: src/i2c_mbe_seq.sv
// Phase sequencer of the I2C master byte engine: state registers and one-tick step logic.
// Depends on i2c_mbe_pkg (phase table, command codes, result type).
module i2c_mbe_seq #(
    parameter int UNIT_COUNTER_WIDTH = i2c_mbe_pkg::UCW_DEFAULT
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_step,
    input  logic [2:0]                                  i_opcode,
    input  logic [7:0]                                  i_tx_byte,
    input  logic                                        i_ack_level,
    input  logic                                        i_sda_in,
    input  logic [i2c_mbe_pkg::UNIT_TICKS_WIDTH-1:0]    i_unit_ticks,
    output i2c_mbe_pkg::t_result                        o_res
);
    import i2c_mbe_pkg::*;

    localparam int UCW = UNIT_COUNTER_WIDTH;

    // State
    logic [4:0]     r_step,   n_step;
    logic [UCW-1:0] r_wait,   n_wait;
    logic [1:0]     r_unit,   n_unit;
    logic [2:0]     r_bit,    n_bit;
    logic [7:0]     r_shift,  n_shift;
    logic [2:0]     r_active, n_active;
    logic           r_scl,    n_scl;
    logic           r_sda,    n_sda;
    logic [7:0]     r_rx,     n_rx;
    logic           r_ack,    n_ack;

    // Step logic
    logic [UCW-1:0] period;
    logic [UCW-1:0] w_inc;
    logic [1:0]     u_inc;
    logic           is_cmd;
    logic           done;
    logic           rej;
    logic           enter;
    logic [4:0]     enter_idx;
    t_phase         ph;
    t_phase         ep;

    // Unit length, reduced to the counter width; zero acts as one
    always_comb begin
        period = '0;
        for (int i = 0; i < UCW; i++) begin
            if (i < UNIT_TICKS_WIDTH) period[i] = i_unit_ticks[i];
        end
        if (period == '0) period = {{(UCW-1){1'b0}}, 1'b1};
    end

    assign is_cmd = (i_opcode == CMD_START) || (i_opcode == CMD_STOP) ||
                    (i_opcode == CMD_WRITE) || (i_opcode == CMD_READ) ||
                    (i_opcode == CMD_ACK);
    assign w_inc  = r_wait + 1'b1;
    assign u_inc  = r_unit + 2'd1;
    assign ph     = phase_rom(r_step);

    // Next state for one tick
    always_comb begin
        n_step    = r_step;
        n_wait    = r_wait;
        n_unit    = r_unit;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_active  = r_active;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_rx      = r_rx;
        n_ack     = r_ack;
        done      = 1'b0;
        rej       = 1'b0;
        enter     = 1'b0;
        enter_idx = r_step;

        if (r_active == CMD_NONE) begin
            // idle: take a new command
            if (is_cmd) begin
                n_active = i_opcode;
                n_bit    = 3'd0;
                case (i_opcode)
                    CMD_WRITE: n_shift = i_tx_byte;
                    CMD_ACK:   n_shift = {i_ack_level, 7'd0};
                    default:   n_shift = 8'd0;
                endcase
                enter     = 1'b1;
                enter_idx = cmd_base(i_opcode);
            end
        end else begin
            rej = is_cmd;
            if (r_step >= 5'(PHASE_COUNT)) begin
                n_active = CMD_NONE;
                n_step   = 5'd0;
            end else if (w_inc >= period) begin
                n_wait = '0;
                n_unit = u_inc;
                if (u_inc >= ph.units) begin
                    if ((ph.flags & FLAG_ACK) != 4'd0) n_ack = ~i_sda_in;
                    if ((ph.flags & FLAG_BIT) != 4'd0) n_shift = {r_shift[6:0], i_sda_in};
                    if ((ph.flags & FLAG_END) != 4'd0) begin
                        if (r_active == CMD_READ) n_rx = n_shift;
                        done     = 1'b1;
                        n_active = CMD_NONE;
                        n_step   = 5'd0;
                        n_unit   = 2'd0;
                        n_bit    = 3'd0;
                    end else if (((ph.flags & FLAG_LOOP) != 4'd0) && (r_bit != 3'd7)) begin
                        n_bit     = r_bit + 3'd1;
                        enter     = 1'b1;
                        enter_idx = ph.target;
                    end else begin
                        if ((ph.flags & FLAG_LOOP) != 4'd0) n_bit = 3'd0;
                        enter     = 1'b1;
                        enter_idx = r_step + 5'd1;
                    end
                end
            end else begin
                n_wait = w_inc;
            end
        end

        // Phase entry: set the lines the new phase names
        ep = phase_rom(enter_idx);
        if (enter) begin
            n_step = enter_idx;
            n_wait = '0;
            n_unit = 2'd0;
            if (enter_idx >= 5'(PHASE_COUNT)) begin
                n_step   = 5'd0;
                n_active = CMD_NONE;
            end else begin
                if (ep.scl != LVL_KEEP) n_scl = ep.scl[0];
                if (ep.sda == LVL_DATA) n_sda = n_shift[3'd7 - n_bit];
                else if (ep.sda != LVL_KEEP) n_sda = ep.sda[0];
            end
        end
    end

    // Result of this tick
    always_comb begin
        o_res.scl_level = n_scl;
        o_res.sda_drive = n_sda;
        o_res.busy_res  = (n_active != CMD_NONE);
        o_res.done_res  = done;
        o_res.rx_byte   = n_rx;
        o_res.ack_seen  = n_ack;
        o_res.rejected  = rej;
    end

    // State registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 5'd0;
            r_wait   <= '0;
            r_unit   <= 2'd0;
            r_bit    <= 3'd0;
            r_shift  <= 8'd0;
            r_active <= CMD_NONE;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_rx     <= 8'd0;
            r_ack    <= 1'b0;
        end else if (i_step) begin
            r_step   <= n_step;
            r_wait   <= n_wait;
            r_unit   <= n_unit;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_active <= n_active;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_rx     <= n_rx;
            r_ack    <= n_ack;
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active == CMD_NONE) |-> (r_unit == 2'd0 && r_bit == 3'd0))
        else $error("idle with live unit or bit count");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < 5'(PHASE_COUNT))
        else $error("phase index out of table");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |=> (r_active == CMD_NONE))
        else $error("command finished but engine still busy");
    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active != CMD_NONE) |-> (r_wait < period || $changed(i_unit_ticks)))
        else $error("tick counter beyond unit length");
`endif

endmodule

FILE: src/i2c_mbe_obuf.sv
// Two-entry result buffer of the I2C master byte engine, parting input and output handshakes.
// Depends on i2c_mbe_pkg (result type).
module i2c_mbe_obuf (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  i2c_mbe_pkg::t_result    i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    input  logic                    i_pop_ready,
    output i2c_mbe_pkg::t_result    o_data
);
    import i2c_mbe_pkg::*;

    t_result    r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_pop_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + 2'd1;
        else if (!i_push && pop) n_count = r_count - 2'd1;
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer overfilled");
    a_fill_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop && r_count == 2'd1) |=> !o_ready)
        else $error("buffer full not flagged");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("pointers disagree with fill count");
`endif

endmodule

FILE: src/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: config register, sequencer and result buffer.
// Depends on i2c_mbe_pkg, i2c_mbe_seq and i2c_mbe_obuf.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  cfg      | i_cfg_valid / o_cfg_ready  | i_cfg_data (unit_ticks)
//  in       | i_in_valid  / o_in_ready   | i_opcode, i_tx_byte, i_ack_level, i_sda_in
//  out      | o_out_valid / i_out_ready  | o_scl_level .. o_rejected
//
// One input beat per clock while the result buffer has room; its result beat is written into the result buffer.
// The step logic is one pass through the phase table between state and result registers.
// A two-entry result buffer keeps input accepted while one result waits downstream;
// input stalls only when both entries are held.
// Synchronous active-low reset: engine idle, SCL and SDA released, unit_ticks = 1.
module i2c_master_byte_engine_core #(
    parameter int UNIT_COUNTER_WIDTH = i2c_mbe_pkg::UCW_DEFAULT
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [i2c_mbe_pkg::UNIT_TICKS_WIDTH-1:0]    i_cfg_data,
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic [2:0]                                  i_opcode,
    input  logic [7:0]                                  i_tx_byte,
    input  logic                                        i_ack_level,
    input  logic                                        i_sda_in,
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic                                        o_scl_level,
    output logic                                        o_sda_drive,
    output logic                                        o_busy_res,
    output logic                                        o_done_res,
    output logic [7:0]                                  o_rx_byte,
    output logic                                        o_ack_seen,
    output logic                                        o_rejected
);
    import i2c_mbe_pkg::*;

    logic [UNIT_TICKS_WIDTH-1:0] r_unit_ticks;
    logic                        step;
    t_result                     seq_res;
    t_result                     out_res;

    // Config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_WIDTH'(1);
        end else if (i_cfg_valid) begin
            r_unit_ticks <= i_cfg_data;
        end
    end

    assign step = i_in_valid && o_in_ready;

    i2c_mbe_seq #(
        .UNIT_COUNTER_WIDTH (UNIT_COUNTER_WIDTH)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_opcode     (i_opcode),
        .i_tx_byte    (i_tx_byte),
        .i_ack_level  (i_ack_level),
        .i_sda_in     (i_sda_in),
        .i_unit_ticks (r_unit_ticks),
        .o_res        (seq_res)
    );

    i2c_mbe_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_data      (seq_res),
        .o_ready     (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (out_res)
    );

    // Result beat onto the ports
    assign o_scl_level = out_res.scl_level;
    assign o_sda_drive = out_res.sda_drive;
    assign o_busy_res  = out_res.busy_res;
    assign o_done_res  = out_res.done_res;
    assign o_rx_byte   = out_res.rx_byte;
    assign o_ack_seen  = out_res.ack_seen;
    assign o_rejected  = out_res.rejected;

endmodule
